@@ sv/crc8fc_pkg.sv @@
// ============================================================================
// CRC-8 frame checker package
// Shared constants, result types and the byte-wide CRC-8 update function.
// ============================================================================
`default_nettype none

package crc8fc_pkg;

  localparam int unsigned CountWidth = 6;
  localparam int unsigned CountMax   = 63;
  localparam int unsigned MinFrame   = 5;
  localparam int unsigned MaxFrame   = 32;
  localparam int unsigned FirstPayloadMinCount = 6;

  localparam logic [7:0] CrcInit   = 8'hFF;
  localparam logic [7:0] CrcPoly   = 8'h31;
  localparam logic [7:0] SyncReset = 8'hAA;

  typedef enum logic [2:0] {
    ST_VALID        = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_BAD_START    = 3'd2,
    ST_BAD_LENGTH   = 3'd3,
    ST_CRC_MISMATCH = 3'd4
  } status_t;

  // Header bytes and byte count of a burst as seen after the current byte, and the CRC of the bytes before it.
  typedef struct packed {
    logic [7:0]            first_byte;
    logic [7:0]            addr_byte;
    logic [7:0]            cmd_byte;
    logic [7:0]            len_byte;
    logic [7:0]            data_byte;
    logic [CountWidth-1:0] count;
    logic [7:0]            crc;
  } burst_view_t;

  // Result item; the first member sits in the highest bits, so the list runs
  // from the top field down to status in the lowest bits.
  typedef struct packed {
    logic [7:0] crc_computed;
    logic [7:0] crc_got;
    logic [7:0] first_payload;
    logic [7:0] payload_len;
    logic [7:0] frame_cmd;
    logic [7:0] frame_addr;
    status_t    status;
  } result_t;

  // MSB-first CRC-8 over one byte.
  function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/crc8_frame_checker_unit.sv @@
// ============================================================================
// CRC-8 frame checker
// Checks receive bursts as framed messages and reports one result per burst.
// ============================================================================
// Received bytes arrive one per transaction on the s_ side; s_tlast marks the
// last byte of a burst. Each burst is checked as a frame made of a start byte,
// an address, a command, a data length, the data bytes and a CRC-8 (polynomial
// 0x31, initial value 0xFF, MSB first, no final XOR) that covers every byte but
// the last. The checks run in order: fewer than five bytes, wrong start byte
// (compared with the sync_byte register, 0xAA after reset), total length not
// five plus the declared length or above the 32-byte frame limit, then CRC
// mismatch. The byte that closes a burst produces one result transaction on
// the m_ side; other bytes produce none. Header fields that were never
// received read as zero. The block takes one byte per clock cycle unless a
// closing byte is held (see below): a byte waits in the input register, the
// CRC and header bookkeeping is a single pass of logic, and the result is
// registered as the closing byte leaves the input register. A waiting
// result does not stop intake of the following burst's bytes; only a second
// result that would overwrite an untaken one holds the input side. sync_byte
// is written over the cfg_ channel, which is always ready, and should only
// change while the block is idle.
`default_nettype none

module crc8_frame_checker_unit
  import crc8fc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  // Configuration: sync_byte[7:0].
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,

  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  wire logic        s_tlast,   // burst_end

  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[2:0], frame_addr[10:3], frame_cmd[18:11], payload_len[26:19],
  // first_payload[34:27], crc_got[42:35], crc_computed[50:43], zero[55:51]
  output logic [55:0]      m_tdata
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        advance;
  logic [7:0]  sync_byte;
  burst_view_t view;
  result_t     result;

  // The configuration register is a plain write-enabled flop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= SyncReset;
    end else if (cfg_valid) begin
      sync_byte <= cfg_data;
    end
  end

  // A byte that does not close a burst is always consumed. The closing byte
  // is consumed when the result register is free or is being emptied in this
  // same cycle.
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  crc8fc_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .rx_byte   (in_byte),
    .burst_end (in_last),
    .view      (view)
  );

  crc8fc_check u_check (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && in_last),
    .view      (view),
    .rx_byte   (in_byte),
    .sync_byte (sync_byte),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .result    (result)
  );

  assign m_tdata = {5'b00000, result};

endmodule

`default_nettype wire

@@ sv/crc8fc_accum.sv @@
// ============================================================================
// CRC-8 frame checker burst accumulator
// Holds the running CRC, the byte count and the header bytes of a burst.
// ============================================================================
`default_nettype none

module crc8fc_accum
  import crc8fc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        burst_end,
  output burst_view_t      view
);

  logic [7:0]            crc_acc;
  logic [CountWidth-1:0] byte_count;
  logic [7:0]            first_byte;
  logic [7:0]            addr_byte;
  logic [7:0]            cmd_byte;
  logic [7:0]            len_byte;
  logic [7:0]            data_byte;

  always_comb begin
    view.first_byte = (byte_count == CountWidth'(0)) ? rx_byte : first_byte;
    view.addr_byte  = (byte_count == CountWidth'(1)) ? rx_byte : addr_byte;
    view.cmd_byte   = (byte_count == CountWidth'(2)) ? rx_byte : cmd_byte;
    view.len_byte   = (byte_count == CountWidth'(3)) ? rx_byte : len_byte;
    view.data_byte  = (byte_count == CountWidth'(4)) ? rx_byte : data_byte;
    view.count      = (byte_count == CountWidth'(CountMax)) ? byte_count
                                                            : byte_count + CountWidth'(1);
    view.crc        = crc_acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc    <= CrcInit;
      byte_count <= '0;
      first_byte <= '0;
      addr_byte  <= '0;
      cmd_byte   <= '0;
      len_byte   <= '0;
      data_byte  <= '0;
    end else if (fire) begin
      if (burst_end) begin
        crc_acc    <= CrcInit;
        byte_count <= '0;
        first_byte <= '0;
        addr_byte  <= '0;
        cmd_byte   <= '0;
        len_byte   <= '0;
        data_byte  <= '0;
      end else begin
        crc_acc    <= crc8_update(crc_acc, rx_byte);
        byte_count <= view.count;
        first_byte <= view.first_byte;
        addr_byte  <= view.addr_byte;
        cmd_byte   <= view.cmd_byte;
        len_byte   <= view.len_byte;
        data_byte  <= view.data_byte;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/crc8fc_check.sv @@
// ============================================================================
// CRC-8 frame checker result stage
// Grades the finished burst and holds the result until it is taken.
// ============================================================================
`default_nettype none

module crc8fc_check
  import crc8fc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire burst_view_t view,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  sync_byte,
  input  wire logic        out_ready,
  output logic             out_valid,
  output result_t          result
);

  result_t    result_next;
  logic [8:0] declared_len;

  always_comb begin
    declared_len = 9'(MinFrame) + {1'b0, view.len_byte};

    if (view.count < CountWidth'(MinFrame)) begin
      result_next.status = ST_TOO_SHORT;
    end else if (view.first_byte != sync_byte) begin
      result_next.status = ST_BAD_START;
    end else if ((view.count > CountWidth'(MaxFrame)) ||
                 ({3'b000, view.count} != declared_len)) begin
      result_next.status = ST_BAD_LENGTH;
    end else if (rx_byte != view.crc) begin
      result_next.status = ST_CRC_MISMATCH;
    end else begin
      result_next.status = ST_VALID;
    end

    result_next.frame_addr    = view.addr_byte;
    result_next.frame_cmd     = view.cmd_byte;
    result_next.payload_len   = view.len_byte;
    // A fifth byte that closes the burst is the checksum, not data.
    result_next.first_payload = (view.count >= CountWidth'(FirstPayloadMinCount))
                                ? view.data_byte : 8'h00;
    result_next.crc_got       = rx_byte;
    result_next.crc_computed  = view.crc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// CRC-8 frame checker testbench
// Streams receive bursts through the checker under random flow control and
// compares every frame report with an independent in-bench prediction.
// ============================================================================
// The bench keeps its own copy of the checker's burst state and sync byte. It
// folds each accepted byte into that copy and queues one expected report per
// burst end. The stimulus opens with a short directed set of bursts, which
// covers the one-byte burst, the shortest valid frame, a bad start byte, a
// declared length that only matches when truncated, and a CRC mismatch. Four
// random phases follow, each under its own sync byte. Most bursts are
// well-formed frames with random content. The rest are broken frames,
// oversized bursts up to and past byte-counter saturation, and noise.
`default_nettype none

module tb;
  import crc8fc_pkg::*;

  localparam int unsigned PhaseBytes  = 490;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned SettleTicks = 8;

  // One received byte waiting to be offered on the input stream.
  typedef struct {
    logic [7:0] data;
    logic       tail;
  } rx_item_t;

  // What the checker should report when a burst closes.
  typedef struct {
    status_t    status;
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] first_data;
    logic [7:0] crc_rx;
    logic [7:0] crc_local;
  } frame_report_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE
  } rx_pattern_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  crc8_frame_checker_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  rx_item_t      byte_queue[$];
  frame_report_t pending_reports[$];
  logic [7:0]    frame_bytes[$];
  int unsigned   error_count = 0;

  // Shadow of the checker's burst state and of its sync_byte register.
  logic [7:0]            sync_model = SyncReset;
  logic [7:0]            crc_model = CrcInit;
  logic [CountWidth-1:0] seen_count = '0;
  logic [7:0]            hdr_start = '0;
  logic [7:0]            hdr_addr = '0;
  logic [7:0]            hdr_cmd = '0;
  logic [7:0]            hdr_len = '0;
  logic [7:0]            hdr_data = '0;

  // Sender burst/gap bookkeeping and receiver stall pattern.
  rx_item_t    next_item;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  rx_pattern_t rx_mode = RX_STEADY;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  logic        hold_request = 1'b0;
  logic        hold_taken = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Bit-serial form of the CRC-8: each data bit, MSB first, is compared with
  // the top bit of the register to decide whether the polynomial is applied.
  function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

  // Folds one accepted byte into the shadow state. A burst end queues the
  // report that the checker must produce and clears the burst.
  task automatic track_frame_byte(input logic [7:0] b, input logic tail);
    frame_report_t rep;
    int unsigned   n;
    case (seen_count)
      0: hdr_start = b;
      1: hdr_addr  = b;
      2: hdr_cmd   = b;
      3: hdr_len   = b;
      4: hdr_data  = b;
      default: ;
    endcase
    n = (seen_count < CountMax) ? seen_count + 1 : CountMax;
    seen_count = n[CountWidth-1:0];
    if (!tail) begin
      crc_model = crc8_fold(crc_model, b);
    end else begin
      // The length test is done at full integer width, so a length byte that
      // only matches after truncation still counts as wrong.
      if (n < MinFrame) begin
        rep.status = ST_TOO_SHORT;
      end else if (hdr_start != sync_model) begin
        rep.status = ST_BAD_START;
      end else if (n > MaxFrame || n != MinFrame + int'(hdr_len)) begin
        rep.status = ST_BAD_LENGTH;
      end else if (b != crc_model) begin
        rep.status = ST_CRC_MISMATCH;
      end else begin
        rep.status = ST_VALID;
      end
      rep.addr       = hdr_addr;
      rep.cmd        = hdr_cmd;
      rep.len        = hdr_len;
      // A fifth byte that closes the burst is the checksum, not data.
      rep.first_data = (n >= FirstPayloadMinCount) ? hdr_data : 8'h00;
      rep.crc_rx     = b;
      rep.crc_local  = crc_model;
      pending_reports.push_back(rep);
      crc_model  = CrcInit;
      seen_count = '0;
      hdr_start  = '0;
      hdr_addr   = '0;
      hdr_cmd    = '0;
      hdr_len    = '0;
      hdr_data   = '0;
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic check_report(input logic [55:0] word);
    frame_report_t want;
    if (pending_reports.size() == 0) begin
      $error("report transaction with no burst end waiting: %h", word);
      error_count++;
    end else begin
      want = pending_reports.pop_front();
      compare_field("status", want.status, word[2:0]);
      compare_field("frame_addr", want.addr, word[10:3]);
      compare_field("frame_cmd", want.cmd, word[18:11]);
      compare_field("payload_len", want.len, word[26:19]);
      compare_field("first_payload", want.first_data, word[34:27]);
      compare_field("crc_got", want.crc_rx, word[42:35]);
      compare_field("crc_computed", want.crc_local, word[50:43]);
      compare_field("pad", 0, word[55:51]);
    end
  endtask

  // Moves the scratch burst onto the input queue, marking its last byte.
  task automatic send_burst();
    rx_item_t it;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      it.data = frame_bytes[i];
      it.tail = (i == frame_bytes.size() - 1);
      byte_queue.push_back(it);
    end
    frame_bytes.delete();
  endtask

  // Builds start, address, command, length field, data bytes and a trailing
  // CRC. crc_flip is XORed into the CRC to corrupt it on purpose.
  task automatic build_frame(input logic [7:0] start, input logic [7:0] len_field,
                             input int unsigned data_count, input logic [7:0] crc_flip);
    logic [7:0] crc;
    logic [7:0] b;
    crc = CrcInit;
    for (int unsigned i = 0; i < 4 + data_count; i++) begin
      if (i == 0) begin
        b = start;
      end else if (i == 3) begin
        b = len_field;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      frame_bytes.push_back(b);
      crc = crc8_fold(crc, b);
    end
    frame_bytes.push_back(crc ^ crc_flip);
    send_burst();
  endtask

  task automatic random_bytes(input logic [7:0] start, input int unsigned count);
    frame_bytes.push_back(start);
    for (int unsigned i = 1; i < count; i++) begin
      frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    send_burst();
  endtask

  // Mostly short payloads, now and then one close to the frame limit.
  function automatic int unsigned pick_len();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(9, MaxFrame - MinFrame);
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic queue_random_phase();
    int unsigned target;
    int unsigned len;
    int unsigned pick;
    target = byte_queue.size() + PhaseBytes;
    while (byte_queue.size() < target) begin
      pick = $urandom_range(0, 99);
      len = pick_len();
      if (pick < 55) begin
        build_frame(sync_model, 8'(len), len, 8'h00);
      end else if (pick < 65) begin
        build_frame(sync_model, 8'(len), len, 8'($urandom_range(1, 255)));
      end else if (pick < 72) begin
        build_frame(sync_model ^ 8'($urandom_range(1, 255)), 8'(len), len, 8'h00);
      end else if (pick < 79) begin
        build_frame(sync_model, 8'(len + $urandom_range(1, 255)), len, 8'h00);
      end else if (pick < 82) begin
        // Consistent length field, but the frame exceeds the size limit.
        len = $urandom_range(MaxFrame - MinFrame + 1, CountMax - MinFrame);
        build_frame(sync_model, 8'(len), len, 8'h00);
      end else if (pick < 84) begin
        // Long enough to come near or reach saturation of the byte counter.
        len = $urandom_range(CountMax - MinFrame - 2, CountMax);
        build_frame(sync_model, 8'(len), len, 8'h00);
      end else if (pick < 92) begin
        random_bytes($urandom_range(0, 1) ? sync_model : 8'($urandom_range(0, 255)),
                     $urandom_range(1, MinFrame - 1));
      end else begin
        random_bytes($urandom_range(0, 1) ? sync_model : 8'($urandom_range(0, 255)),
                     $urandom_range(1, 12));
      end
    end
  endtask

  // Waits until every byte has been taken and every report has arrived, then
  // lets the pipeline settle.
  task automatic drain();
    while (byte_queue.size() != 0 || s_tvalid || pending_reports.size() != 0) begin
      @(negedge clk);
    end
    repeat (SettleTicks) @(posedge clk);
  endtask

  task automatic write_sync(input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Input driver: offers queued bytes in bursts of random length separated by
  // random gaps. A new byte is only presented once the previous transaction
  // has completed.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        next_item = byte_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_item.data;
        s_tlast  <= next_item.tail;
        if (burst_left > 0) begin
          burst_left--;
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output ready pattern. The mode changes every so often; on request there is
  // one long hold-off, during which the sender keeps offering bytes, so that
  // the checker fills up and has to stall its input.
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 97 == 0) begin
      rx_mode = rx_pattern_t'($urandom_range(0, 2));
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = LongHold;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        default:   m_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // Monitor: tracks register writes, checks report transactions and feeds
  // accepted bytes to the prediction, all on the same sampled edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        sync_model = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        check_report(m_tdata);
      end
      if (s_tvalid && s_tready) begin
        track_frame_byte(s_tdata, s_tlast);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [7:0] phase_sync[3];
    phase_sync[0] = 8'h00;
    phase_sync[1] = 8'hFF;
    phase_sync[2] = 8'($urandom_range(0, 255));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed bursts under the reset sync byte.
    random_bytes(8'($urandom_range(0, 255)), 1);      // single byte
    build_frame(sync_model, 8'd0, 0, 8'h00);          // shortest valid frame
    build_frame(sync_model, 8'd1, 1, 8'h00);          // first data byte present
    random_bytes(sync_model, MinFrame - 1);           // one byte too short
    build_frame(sync_model ^ 8'h01, 8'd0, 0, 8'h00);  // bad start byte
    build_frame(sync_model, 8'd64, 0, 8'h00);         // length matches only in 6 bits
    build_frame(sync_model, 8'd0, 0, 8'h80);          // CRC mismatch

    queue_random_phase();
    hold_request = 1'b1;
    drain();

    for (int p = 0; p < 3; p++) begin
      write_sync(phase_sync[p]);
      repeat (2) @(posedge clk);
      queue_random_phase();
      drain();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/crc8fc_pkg.sv
sv/crc8fc_accum.sv
sv/crc8fc_check.sv
sv/crc8_frame_checker_unit.sv
test/tb.sv
